// ===== hw/rtl/folded_string_compare_defines.svh =====
// Assertion macros for the folded string compare block.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef FOLDED_STRING_COMPARE_DEFINES_SVH
`define FOLDED_STRING_COMPARE_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define FSC_ASSERT(name_, prop_) \
  name_: assert property (@(posedge clk_i) disable iff (!rst_ni) prop_) \
    else $error("folded_string_compare: check failed");

// Expression must never be true outside reset.
`define FSC_ASSERT_NEVER(name_, expr_) \
  name_: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr_)) \
    else $error("folded_string_compare: forbidden condition seen");

`endif

// ===== hw/rtl/fsc_pkg.sv =====
// Package for the folded string compare block: counter width, register
// indexes and the character folding functions. No dependencies.
package fsc_pkg;

  localparam int unsigned COUNT_BITS = 16;
  // Width used when comparing the pair counter with the 16-bit limit
  localparam int unsigned CNT_CMP_W  = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  localparam int unsigned FOLD_RANGES = 12;

  typedef enum logic [1:0] {
    REG_FOLD_CASE    = 2'd0,
    REG_WIDE_CHARS   = 2'd1,
    REG_LIMIT_ENABLE = 2'd2,
    REG_LENGTH_LIMIT = 2'd3
  } cfg_reg_e;

  typedef logic signed [16:0] code_t;

  // Half-open ranges [lo, end) of capitals and the offset to their lower case
  localparam logic [15:0] FOLD_LO [FOLD_RANGES] = '{
    16'h0041, 16'h00c0, 16'h00d8, 16'h0189, 16'h01b1, 16'h0388,
    16'h038e, 16'h0391, 16'h03a3, 16'h0400, 16'h0410, 16'h0531
  };
  localparam logic [15:0] FOLD_END [FOLD_RANGES] = '{
    16'h005b, 16'h00d7, 16'h00df, 16'h018b, 16'h01b3, 16'h038b,
    16'h0390, 16'h03a2, 16'h03ac, 16'h0410, 16'h0430, 16'h0557
  };
  localparam logic [7:0] FOLD_ADD [FOLD_RANGES] = '{
    8'd32, 8'd32, 8'd32, 8'd205, 8'd217, 8'd37,
    8'd63, 8'd32, 8'd32, 8'd80, 8'd32, 8'd48
  };

  // UTF-16 unit, optionally folded; ranges are disjoint
  function automatic code_t wide_value(logic [15:0] c, logic fold);
    code_t res;
    res = code_t'({1'b0, c});
    if (fold) begin
      for (int i = 0; i < FOLD_RANGES; i++) begin
        if (c >= FOLD_LO[i] && c < FOLD_END[i]) begin
          res = code_t'({1'b0, c}) + code_t'({9'd0, FOLD_ADD[i]});
        end
      end
    end
    return res;
  endfunction

  // Low byte as a signed byte, ASCII capitals optionally folded
  function automatic code_t narrow_value(logic [7:0] c, logic fold);
    code_t res;
    res = code_t'({{9{c[7]}}, c});
    if (fold && c >= 8'h41 && c <= 8'h5a) begin
      res = res + code_t'(17'd32);
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/folded_string_compare.sv =====
// Folded string compare, top level: input register, compare logic,
// result register and APB-style configuration registers.
// Depends on fsc_pkg and folded_string_compare_defines.svh.
//
// Usage: character pairs of strings A and B stream in on the input channel
// (char_a_i, char_b_i, first_pair_i) under valid/ready. A pair with
// first_pair_i set starts a new comparison. A comparison yields exactly one
// result item (difference_o, position_o) at the first mismatch, at the end
// of either string, or when the length limit is reached; later pairs are
// dropped until the next first pair. Pairs that decide nothing give no item.
// An accepted pair waits in the input register; its result is written into the
// result register when the pair moves on, which waits while a result is held.
// Throughput: one pair per cycle while the receiver takes results; the input
// and result registers each hold one item, and the compare is combinational
// logic between them. When the receiver stalls, the result register holds and
// the input register fills; ready then drops until the result is taken. Reset
// clears the valid flags of both registers, the pair counter, and sets the
// block idle (waiting for a first pair); configuration resets to raw compare,
// wide characters, no limit. Configuration must be written over the APB-style
// port only while no item is in flight; the block does not enforce this.
`include "folded_string_compare_defines.svh"

module folded_string_compare
  import fsc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // pair input
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [15:0]        char_a_i,
  input  logic [15:0]        char_b_i,
  input  logic               first_pair_i,
  // result output
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [16:0] difference_o,
  output logic [15:0]        position_o,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // configuration registers
  logic        fold_case_q;
  logic        wide_chars_q;
  logic        limit_enable_q;
  logic [15:0] length_limit_q;

  logic     cfg_we;
  cfg_reg_e cfg_sel;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_sel = cfg_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_case_q    <= 1'b0;
      wide_chars_q   <= 1'b1;
      limit_enable_q <= 1'b0;
      length_limit_q <= 16'd0;
    end else if (cfg_we) begin
      case (cfg_sel)
        REG_FOLD_CASE:    fold_case_q    <= pwdata[0];
        REG_WIDE_CHARS:   wide_chars_q   <= pwdata[0];
        REG_LIMIT_ENABLE: limit_enable_q <= pwdata[0];
        REG_LENGTH_LIMIT: length_limit_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_FOLD_CASE:    prdata = {31'd0, fold_case_q};
      REG_WIDE_CHARS:   prdata = {31'd0, wide_chars_q};
      REG_LIMIT_ENABLE: prdata = {31'd0, limit_enable_q};
      REG_LENGTH_LIMIT: prdata = {16'd0, length_limit_q};
      default:          prdata = 32'd0;
    endcase
  end

  // input register
  logic        s1_valid_q;
  logic [15:0] char_a_q;
  logic [15:0] char_b_q;
  logic        first_q;
  logic        s2_go;

  assign s2_go      = s1_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !s1_valid_q || s2_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      char_a_q <= char_a_i;
      char_b_q <= char_b_i;
      first_q  <= first_pair_i;
    end
  end

  // compare state
  logic                  decided_q, decided_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;

  logic                  cur_decided;
  logic [COUNT_BITS-1:0] cur_cnt;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic                  limit_now;
  logic                  limit_next;
  code_t                 va, vb;
  logic signed [17:0]    diff_full;
  logic                  at_end;
  logic                  emit;
  logic signed [16:0]    res_diff;
  logic [15:0]           res_pos;

  assign cur_decided = first_q ? 1'b0 : decided_q;
  assign cur_cnt     = first_q ? '0 : cnt_q;
  assign cnt_inc     = cur_cnt + 1'b1;
  assign limit_now   = limit_enable_q &&
                       (CNT_CMP_W'(cur_cnt) >= CNT_CMP_W'(length_limit_q));
  assign limit_next  = limit_enable_q &&
                       (CNT_CMP_W'(cnt_inc) >= CNT_CMP_W'(length_limit_q));

  always_comb begin
    if (wide_chars_q) begin
      va     = wide_value(char_a_q, fold_case_q);
      vb     = wide_value(char_b_q, fold_case_q);
      at_end = (char_a_q == 16'd0) || (char_b_q == 16'd0);
    end else begin
      va     = narrow_value(char_a_q[7:0], fold_case_q);
      vb     = narrow_value(char_b_q[7:0], fold_case_q);
      at_end = (char_a_q[7:0] == 8'd0) || (char_b_q[7:0] == 8'd0);
    end
  end

  assign diff_full = {va[16], va} - {vb[16], vb};

  always_comb begin
    decided_d = cur_decided;
    cnt_d     = cur_cnt;
    emit      = 1'b0;
    res_diff  = '0;
    res_pos   = 16'(cur_cnt);
    if (!cur_decided) begin
      if (limit_now) begin
        // limit already reached: pair not compared
        emit      = 1'b1;
        decided_d = 1'b1;
      end else if (va != vb || at_end) begin
        emit      = 1'b1;
        decided_d = 1'b1;
        res_diff  = diff_full[16:0];
      end else begin
        cnt_d = cnt_inc;
        if (limit_next) begin
          // last allowed pair matched
          emit      = 1'b1;
          decided_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decided_q <= 1'b1;
      cnt_q     <= '0;
    end else if (s2_go) begin
      decided_q <= decided_d;
      cnt_q     <= cnt_d;
    end
  end

  // result register
  logic               out_valid_q;
  logic signed [16:0] diff_q;
  logic [15:0]        pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_go) begin
      out_valid_q <= emit;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_go && emit) begin
      diff_q <= res_diff;
      pos_q  <= res_pos;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign difference_o = diff_q;
  assign position_o   = pos_q;

  // a result always leaves the block idle until the next first pair
  `FSC_ASSERT(a_emit_sets_decided, s2_go && emit |=> decided_q)
  // an idle block with no first pair produces nothing
  `FSC_ASSERT_NEVER(a_idle_no_emit, s2_go && !first_q && decided_q && emit)
  // backpressure only comes from a full pipeline
  `FSC_ASSERT(a_ready_low_full, !in_ready_o |-> s1_valid_q && out_valid_q)

endmodule
